@@ hdl/stack_calculator_alu_top_assert.svh @@
// Assertion macros for the stack calculator checker.
// Depends on nothing; taken in by the checker file through an include.
`ifndef STACK_CALCULATOR_ALU_TOP_ASSERT_SVH
`define STACK_CALCULATOR_ALU_TOP_ASSERT_SVH

// Same-cycle implication, silent during reset.
`define SAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, silent during reset.
`define SAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sac_pkg.sv @@
// Shared types and constants of the stack calculator: opcodes, status codes,
// command and result payloads, and the control word of a stack cell.
package sac_pkg;

    localparam int DATA_W  = 32;
    localparam int DEPTH_W = 6;
    localparam int OPC_W   = 4;
    localparam int STAT_W  = 2;

    localparam logic [OPC_W-1:0] OP_PUSH   = 4'd0;
    localparam logic [OPC_W-1:0] OP_ADD    = 4'd1;
    localparam logic [OPC_W-1:0] OP_SUB    = 4'd2;
    localparam logic [OPC_W-1:0] OP_MUL    = 4'd3;
    localparam logic [OPC_W-1:0] OP_DIV    = 4'd4;
    localparam logic [OPC_W-1:0] OP_MOD    = 4'd5;
    localparam logic [OPC_W-1:0] OP_NEG    = 4'd6;
    localparam logic [OPC_W-1:0] OP_INV    = 4'd7;
    localparam logic [OPC_W-1:0] OP_AND    = 4'd8;
    localparam logic [OPC_W-1:0] OP_OR     = 4'd9;
    localparam logic [OPC_W-1:0] OP_XOR    = 4'd10;
    localparam logic [OPC_W-1:0] OP_SHL    = 4'd11;
    localparam logic [OPC_W-1:0] OP_SHR    = 4'd12;
    localparam logic [OPC_W-1:0] OP_RAMOFS = 4'd13;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UNDER = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVER  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DIVZ  = 2'd3;

    // Register map: word index is paddr[2].
    localparam logic REG_RAM_OFFSET = 1'b0;

    localparam logic [DATA_W-1:0] RAM_OFFSET_RESET = 32'h1000_0000;

    typedef struct packed {
        logic [OPC_W-1:0]         opcode;
        logic signed [DATA_W-1:0] push_value;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       stack_depth;
        logic [STAT_W-1:0]        status;
    } result_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctl_t;

endpackage

@@ hdl/sac_cell.sv @@
// One entry of the stack chain below the top register.
// Depends on sac_pkg (cell_ctl_t, DATA_W).
module sac_cell (
    input  logic                         clk,
    input  sac_pkg::cell_ctl_t           ctl,
    input  logic [sac_pkg::DATA_W-1:0]   above,
    input  logic [sac_pkg::DATA_W-1:0]   below,
    output logic [sac_pkg::DATA_W-1:0]   data
);
    import sac_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // Push moves entries away from the top, pop moves them toward it.
    always_comb
    begin
        data_next = data_reg;
        if (ctl.push)
        begin
            data_next = above;
        end
        else if (ctl.pop)
        begin
            data_next = below;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ hdl/sac_divider.sv @@
// Signed 32-bit restoring divider, one quotient bit per cycle.
// Depends on sac_pkg (DATA_W).
module sac_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sac_pkg::DATA_W-1:0] dividend,
    input  logic [sac_pkg::DATA_W-1:0] divisor,
    output logic [sac_pkg::DATA_W-1:0] quotient,
    output logic [sac_pkg::DATA_W-1:0] remainder,
    output logic                       done
);
    import sac_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_W - 1);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic              neg_q_reg, neg_q_next;
    logic              neg_r_reg, neg_r_next;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        run_next   = run_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        if (start)
        begin
            // Load magnitudes; the most negative value maps onto itself as unsigned.
            run_next   = 1'b1;
            cnt_next   = '0;
            rem_next   = '0;
            quo_next   = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            dvs_next   = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            neg_q_next = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            neg_r_next = dividend[DATA_W-1];
        end
        else if (run_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    // Apply signs: quotient truncates toward zero, remainder follows the dividend.
    assign quotient  = neg_q_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = neg_r_reg ? (~rem_reg + 1'b1) : rem_reg;
    assign done      = done_reg;

endmodule

@@ hdl/stack_calculator_alu_top.sv @@
// Top level of the stack calculator: cached top register, a chain of stack cells,
// the ALU, a shared iterative divider and the APB configuration register.
// Depends on sac_pkg, sac_cell and sac_divider.
//
//  channel   | transfer when                          | payload
//  ----------+----------------------------------------+-----------------------
//  command   | start && !busy at rising clk           | cmd (opcode, push_value)
//  result    | done high for one cycle                | result (top, depth, status)
//  config    | psel && penable && pwrite && pready    | pwdata at paddr
//
//  Push, add, sub, mul, logic ops, shifts, negate, invert, ram offset, unused
//  opcodes and every flagged command bypass the divider: done follows in the
//  cycle after the transfer and busy stays low. Div and mod run on the
//  one-bit-per-cycle divider: load, 32 steps and write-back, after which done
//  rises, with busy high in between. rst_n clears the count, top, the state and
//  done at once and loads ram_offset with RAM_OFFSET_RESET; stack cells hold no
//  reset. The receiver cannot stall: done is a single-cycle strobe.
module stack_calculator_alu_top #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // command channel
    input  logic                       start,
    output logic                       busy,
    input  sac_pkg::cmd_t              cmd,
    // result channel
    output logic                       done,
    output sac_pkg::result_t           result,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [sac_pkg::DATA_W-1:0] pwdata,
    output logic [sac_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import sac_pkg::*;

    localparam int NUM_CELLS = STACK_DEPTH - 1;
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DIV  = 1'b1;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] ram_offset_reg, ram_offset_next;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_RAM_OFFSET);

    always_comb
    begin
        ram_offset_next = ram_offset_reg;
        if (cfg_write)
        begin
            ram_offset_next = pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_RAM_OFFSET) ? ram_offset_reg : '0;

    // ------------------------------------------------------------------
    // Stack state: top register, entry count and the cell chain
    // ------------------------------------------------------------------
    logic              state_reg, state_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              want_rem_reg, want_rem_next;
    cell_ctl_t         cell_ctl;
    logic [DATA_W-1:0] cell_data [NUM_CELLS];

    genvar gi;
    generate
        for (gi = 0; gi < NUM_CELLS; gi++)
        begin : g_cell
            logic [DATA_W-1:0] above_w;
            logic [DATA_W-1:0] below_w;
            // First cell takes the old top on push; the last one has nothing below.
            if (gi == 0)
            begin : g_first
                assign above_w = top_reg;
            end
            else
            begin : g_mid
                assign above_w = cell_data[gi-1];
            end
            if (gi == NUM_CELLS - 1)
            begin : g_last
                assign below_w = cell_data[gi];
            end
            else
            begin : g_inner
                assign below_w = cell_data[gi+1];
            end
            sac_cell u_cell (
                .clk   (clk),
                .ctl   (cell_ctl),
                .above (above_w),
                .below (below_w),
                .data  (cell_data[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // ALU: second entry is the left operand, top the right
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] left_op;
    logic [DATA_W-1:0] right_op;
    logic [DATA_W-1:0] alu_res;
    logic              big_shift;

    assign left_op   = cell_data[0];
    assign right_op  = top_reg;
    assign big_shift = |right_op[DATA_W-1:5];

    always_comb
    begin
        case (cmd.opcode)
            OP_ADD:  alu_res = left_op + right_op;
            OP_SUB:  alu_res = left_op - right_op;
            OP_MUL:  alu_res = left_op * right_op;
            OP_AND:  alu_res = left_op & right_op;
            OP_OR:   alu_res = left_op | right_op;
            OP_XOR:  alu_res = left_op ^ right_op;
            OP_SHL:  alu_res = big_shift ? '0 : (left_op << right_op[4:0]);
            OP_SHR:  alu_res = big_shift ? '0 : (left_op >> right_op[4:0]);
            default: alu_res = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Divider, shared by div and mod
    // ------------------------------------------------------------------
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quo;
    logic [DATA_W-1:0] div_rem;

    sac_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (left_op),
        .divisor   (right_op),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // ------------------------------------------------------------------
    // Command sequencing
    // ------------------------------------------------------------------
    logic              accept;
    logic              out_fire;
    logic [STAT_W-1:0] stat;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next    = state_reg;
        top_next      = top_reg;
        cnt_next      = cnt_reg;
        want_rem_next = want_rem_reg;
        cell_ctl      = '0;
        div_start     = 1'b0;
        out_fire      = 1'b0;
        stat          = STAT_OK;
        if (accept)
        begin
            out_fire = 1'b1;
            case (cmd.opcode)
                OP_PUSH:
                begin
                    if (cnt_reg >= CNT_FULL)
                    begin
                        stat = STAT_OVER;
                    end
                    else
                    begin
                        cell_ctl.push = 1'b1;
                        top_next      = cmd.push_value;
                        cnt_next      = cnt_reg + 1'b1;
                    end
                end
                OP_NEG, OP_INV, OP_RAMOFS:
                begin
                    if (cnt_reg < CNT_ONE)
                    begin
                        stat = STAT_UNDER;
                    end
                    else if (cmd.opcode == OP_NEG)
                    begin
                        top_next = '0 - top_reg;
                    end
                    else if (cmd.opcode == OP_INV)
                    begin
                        top_next = ~top_reg;
                    end
                    else
                    begin
                        top_next = top_reg + ram_offset_reg;
                    end
                end
                OP_DIV, OP_MOD:
                begin
                    if (cnt_reg < CNT_TWO)
                    begin
                        stat = STAT_UNDER;
                    end
                    else if (right_op == '0)
                    begin
                        stat = STAT_DIVZ;
                    end
                    else
                    begin
                        // Hold the result until the divider finishes.
                        out_fire      = 1'b0;
                        div_start     = 1'b1;
                        want_rem_next = (cmd.opcode == OP_MOD);
                        state_next    = S_DIV;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR:
                begin
                    if (cnt_reg < CNT_TWO)
                    begin
                        stat = STAT_UNDER;
                    end
                    else
                    begin
                        cell_ctl.pop = 1'b1;
                        top_next     = alu_res;
                        cnt_next     = cnt_reg - 1'b1;
                    end
                end
                default:
                begin
                    // Unused opcodes leave the stack alone and report ok.
                end
            endcase
        end
        else if (state_reg == S_DIV && div_done)
        begin
            // Write back the quotient or remainder and pop the left operand.
            out_fire     = 1'b1;
            cell_ctl.pop = 1'b1;
            top_next     = want_rem_reg ? div_rem : div_quo;
            cnt_next     = cnt_reg - 1'b1;
            state_next   = S_IDLE;
        end
    end

    // ------------------------------------------------------------------
    // Result register: one-cycle strobe
    // ------------------------------------------------------------------
    logic    done_reg, done_next;
    result_t result_reg, result_next;

    always_comb
    begin
        done_next   = out_fire;
        result_next = result_reg;
        if (out_fire)
        begin
            result_next.top_value   = top_next;
            result_next.stack_depth = DEPTH_W'(cnt_next);
            result_next.status      = stat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            top_reg        <= '0;
            cnt_reg        <= '0;
            done_reg       <= 1'b0;
            ram_offset_reg <= RAM_OFFSET_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            top_reg        <= top_next;
            cnt_reg        <= cnt_next;
            done_reg       <= done_next;
            ram_offset_reg <= ram_offset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        want_rem_reg <= want_rem_next;
        result_reg   <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ hdl/sac_checker.sv @@
// Port-level checker for the stack calculator, bound to the top level.
// Depends on sac_pkg and the macros in stack_calculator_alu_top_assert.svh.
`include "stack_calculator_alu_top_assert.svh"

module sac_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input sac_pkg::result_t result
);
    import sac_pkg::*;

    // A result strobe always comes with the block free for the next command.
    `SAC_ASSERT_NOW(a_done_not_busy, clk, rst_n, done, !busy, "result strobe while busy")

    // Every transfer gives a result next cycle or starts a long operation.
    `SAC_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, done || busy, "command transfer lost")

    // Busy only rises from a command transfer.
    `SAC_ASSERT_NOW(a_busy_cause, clk, rst_n, $rose(busy), $past(start), "busy without a command")

    // Underflow is reported only with fewer than two entries held.
    `SAC_ASSERT_NOW(a_under_depth, clk, rst_n, done && (result.status == STAT_UNDER), result.stack_depth < 6'd2, "underflow with a deep stack")

endmodule

bind stack_calculator_alu_top sac_checker u_sac_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
